// File: rtl/core/lsts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsts_pkg
// shared widths and the control word that walks down the prefix cell row
// ----------------------------------------------------------------------------
package lsts_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned WANT_W  = SUM_W + 1;

  typedef struct packed {
    logic valid;
    logic active;
    logic last;
    logic ovf;
    logic found;
  } ctl_t;

endpackage

// File: rtl/core/lsts_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsts_cell
// one position of the prefix table: holds the prefix of its position, checks
// a passing query against it and stores the prefix carried by its own item
// ----------------------------------------------------------------------------
module lsts_cell #(
  parameter int unsigned POS   = 0,
  parameter int unsigned LEN_W = 11
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  lsts_pkg::ctl_t              ctl_i,
  input  logic [LEN_W-1:0]            idx_i,
  input  logic [lsts_pkg::WANT_W-1:0] want_i,
  input  logic [lsts_pkg::SUM_W-1:0]  prefix_i,
  input  logic [LEN_W-1:0]            len_i,
  output lsts_pkg::ctl_t              ctl_o,
  output logic [LEN_W-1:0]            idx_o,
  output logic [lsts_pkg::WANT_W-1:0] want_o,
  output logic [lsts_pkg::SUM_W-1:0]  prefix_o,
  output logic [LEN_W-1:0]            len_o
);

  localparam logic [LEN_W-1:0] PosVal = LEN_W'(POS);

  logic [lsts_pkg::SUM_W-1:0]  stored_q;
  logic [lsts_pkg::WANT_W-1:0] stored_ext;
  logic                        hit;
  lsts_pkg::ctl_t              ctl_d, ctl_q;
  logic [LEN_W-1:0]            len_d, len_q;
  logic [LEN_W-1:0]            idx_q;
  logic [lsts_pkg::WANT_W-1:0] want_q;
  logic [lsts_pkg::SUM_W-1:0]  prefix_q;

  generate
    if (POS == 0) begin : g_empty
      // position 0 is the empty prefix
      assign stored_q = '0;
    end else begin : g_entry
      logic wr;
      assign wr = ctl_i.valid && ctl_i.active && (idx_i == PosVal);
      always_ff @(posedge clk_i) begin
        if (adv_i && wr) begin
          stored_q <= prefix_i;
        end
      end
    end
  endgenerate

  assign stored_ext = {stored_q[lsts_pkg::SUM_W-1], stored_q};
  assign hit = ctl_i.valid && ctl_i.active && !ctl_i.found && (idx_i > PosVal)
               && (want_i == stored_ext);

  always_comb begin
    ctl_d = ctl_i;
    len_d = len_i;
    if (hit) begin
      ctl_d.found = 1'b1;
      len_d       = idx_i - PosVal;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (adv_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      len_q    <= len_d;
      idx_q    <= idx_i;
      want_q   <= want_i;
      prefix_q <= prefix_i;
    end
  end

  assign ctl_o    = ctl_q;
  assign idx_o    = idx_q;
  assign want_o   = want_q;
  assign prefix_o = prefix_q;
  assign len_o    = len_q;

endmodule

// File: rtl/core/longest_subarray_target_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_subarray_target_sum
// longest contiguous run of a streamed sequence that adds up to target_sum
// ----------------------------------------------------------------------------
// One transaction is accepted per cycle while no result waits on out_ready_i;
// each gives one result after the entry register, one cell per table position and
// the output register. The whole row moves together and holds while a result
// waits on out_ready_i. Each cell keeps the prefix of one position; a query walks
// the row in order behind the items before it, so it finds the earliest matching
// position without any table lookup port. Items past MAX_ITEMS in a sequence are
// not stored and set overflow until the item marked last. The user must write
// target_sum through cfg_we_i / cfg_wdata_i while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module longest_subarray_target_sum #(
  parameter int unsigned MAX_ITEMS = 1024,
  localparam int unsigned LEN_W    = $clog2(MAX_ITEMS + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic signed [lsts_pkg::SUM_W-1:0]   cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [lsts_pkg::VALUE_W-1:0] value_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [LEN_W-1:0]                    best_length_o,
  output logic                                seq_end_o,
  output logic                                overflow_o
);

  localparam logic [LEN_W-1:0] MaxVal = LEN_W'(MAX_ITEMS);

  logic                        adv;
  logic                        accept;
  logic                        active;
  logic [lsts_pkg::SUM_W-1:0]  target_q;
  logic [lsts_pkg::SUM_W-1:0]  sum_d, sum_q;
  logic [LEN_W-1:0]            count_d, count_q;
  logic                        cap_d, cap_q;
  logic [lsts_pkg::SUM_W-1:0]  new_sum;

  lsts_pkg::ctl_t              ent_ctl_d, ent_ctl_q;
  logic [LEN_W-1:0]            ent_idx_q;
  logic [lsts_pkg::SUM_W-1:0]  ent_prefix_q;

  lsts_pkg::ctl_t              ctl_w    [0:MAX_ITEMS];
  logic [LEN_W-1:0]            idx_w    [0:MAX_ITEMS];
  logic [lsts_pkg::WANT_W-1:0] want_w   [0:MAX_ITEMS];
  logic [lsts_pkg::SUM_W-1:0]  prefix_w [0:MAX_ITEMS];
  logic [LEN_W-1:0]            len_w    [0:MAX_ITEMS];

  logic                        out_valid_q;
  logic [LEN_W-1:0]            out_best_q;
  logic                        out_end_q;
  logic                        out_ovf_q;
  logic [LEN_W-1:0]            best_d, best_q;
  logic [LEN_W-1:0]            best_new;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;
  assign active     = (count_q != MaxVal);
  assign new_sum    = sum_q + {{(lsts_pkg::SUM_W - lsts_pkg::VALUE_W){value_i[lsts_pkg::VALUE_W-1]}},
                               value_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
    end else if (cfg_we_i) begin
      target_q <= cfg_wdata_i;
    end
  end

  // sequence state
  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    cap_d   = cap_q;
    if (accept) begin
      if (active) begin
        sum_d   = new_sum;
        count_d = count_q + 1'b1;
      end else begin
        cap_d = 1'b1;
      end
      if (last_i) begin
        sum_d   = '0;
        count_d = '0;
        cap_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      cap_q   <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
      cap_q   <= cap_d;
    end
  end

  // entry register
  always_comb begin
    ent_ctl_d        = '0;
    ent_ctl_d.valid  = in_valid_i;
    ent_ctl_d.active = active;
    ent_ctl_d.last   = last_i;
    ent_ctl_d.ovf    = cap_q || !active;
    ent_ctl_d.found  = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_ctl_q <= '0;
    end else if (adv) begin
      ent_ctl_q <= ent_ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ent_idx_q    <= count_q + 1'b1;
      ent_prefix_q <= new_sum;
    end
  end

  assign ctl_w[0]    = ent_ctl_q;
  assign idx_w[0]    = ent_idx_q;
  assign prefix_w[0] = ent_prefix_q;
  assign len_w[0]    = '0;
  assign want_w[0]   = {ent_prefix_q[lsts_pkg::SUM_W-1], ent_prefix_q}
                     - {target_q[lsts_pkg::SUM_W-1], target_q};

  // one cell per table position
  for (genvar p = 0; p < MAX_ITEMS; p++) begin : g_cell
    lsts_cell #(
      .POS   (p),
      .LEN_W (LEN_W)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .adv_i    (adv),
      .ctl_i    (ctl_w[p]),
      .idx_i    (idx_w[p]),
      .want_i   (want_w[p]),
      .prefix_i (prefix_w[p]),
      .len_i    (len_w[p]),
      .ctl_o    (ctl_w[p+1]),
      .idx_o    (idx_w[p+1]),
      .want_o   (want_w[p+1]),
      .prefix_o (prefix_w[p+1]),
      .len_o    (len_w[p+1])
    );
  end

  // running best and output register
  always_comb begin
    best_new = best_q;
    if (ctl_w[MAX_ITEMS].found && (len_w[MAX_ITEMS] > best_q)) begin
      best_new = len_w[MAX_ITEMS];
    end
    best_d = best_q;
    if (adv && ctl_w[MAX_ITEMS].valid) begin
      best_d = ctl_w[MAX_ITEMS].last ? '0 : best_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      best_q <= best_d;
      if (adv) begin
        out_valid_q <= ctl_w[MAX_ITEMS].valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_best_q <= best_new;
      out_end_q  <= ctl_w[MAX_ITEMS].last;
      out_ovf_q  <= ctl_w[MAX_ITEMS].ovf;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign best_length_o = out_best_q;
  assign seq_end_o     = out_end_q;
  assign overflow_o    = out_ovf_q;

endmodule
